@@ sv/bcgd_pkg.sv @@
package bcgd_pkg;

	localparam int TimeBits   = 32;
	localparam int NumButtons = 5;
	localparam int CfgBits    = 16;

	// config register index
	localparam logic [2:0] CfgDebounce    = 3'd0;
	localparam logic [2:0] CfgLongPress   = 3'd1;
	localparam logic [2:0] CfgDoubleGap   = 3'd2;
	localparam logic [2:0] CfgRepeat      = 3'd3;
	localparam logic [2:0] CfgActiveLevel = 3'd4;

	localparam logic [CfgBits-1:0]    DebounceReset  = 16'd20;
	localparam logic [CfgBits-1:0]    LongPressReset = 16'd500;
	localparam logic [CfgBits-1:0]    DoubleGapReset = 16'd250;
	localparam logic [CfgBits-1:0]    RepeatReset    = 16'd100;
	localparam logic [NumButtons-1:0] ActiveReset    = 5'd0;

	typedef enum logic [2:0] {
		PH_IDLE        = 3'd0,
		PH_PRESSED     = 3'd1,
		PH_WAIT_DOUBLE = 3'd2,
		PH_SECOND      = 3'd3,
		PH_LONG        = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SINGLE = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_HOLD   = 2'd3
	} ev_t;

	typedef struct packed {
		logic [CfgBits-1:0]    debounce_ms;
		logic [CfgBits-1:0]    long_press_ms;
		logic [CfgBits-1:0]    double_gap_ms;
		logic [CfgBits-1:0]    repeat_ms;
		logic [NumButtons-1:0] active_levels;
	} cfg_t;

	// priority order K, U, D, L, R mapped to pin bit, and first command code - 1
	localparam logic [2:0] PrioBit [NumButtons] = '{3'd4, 3'd0, 3'd1, 3'd2, 3'd3};
	localparam logic [3:0] CmdBase [NumButtons] = '{4'd0, 4'd3, 4'd6, 4'd9, 4'd12};

endpackage

@@ sv/button_click_gesture_detector.sv @@
// Each accepted sample's command word is captured in the output register.
// Throughput: one sample per cycle while in_stall is low; all five button lanes and the priority merge
// are combinational, the output register is the only stage.
// in_stall is high only while a command word waits and out_stall holds it.
// Reset: all buttons idle, output empty, config registers at 20/500/250/100/0.
module button_click_gesture_detector import bcgd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [NumButtons-1:0] pin_levels,
	input  logic [TimeBits-1:0]   now_ms,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [3:0]            command,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [CfgBits-1:0]    cfg_data
);

	cfg_t                  cfg_q;
	logic                  step;
	logic [NumButtons-1:0] pressed;
	ev_t                   ev [NumButtons];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= DebounceReset;
			cfg_q.long_press_ms <= LongPressReset;
			cfg_q.double_gap_ms <= DoubleGapReset;
			cfg_q.repeat_ms     <= RepeatReset;
			cfg_q.active_levels <= ActiveReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CfgDebounce:    cfg_q.debounce_ms   <= cfg_data;
				CfgLongPress:   cfg_q.long_press_ms <= cfg_data;
				CfgDoubleGap:   cfg_q.double_gap_ms <= cfg_data;
				CfgRepeat:      cfg_q.repeat_ms     <= cfg_data;
				CfgActiveLevel: cfg_q.active_levels <= cfg_data[NumButtons-1:0];
				default: ;
			endcase
		end
	end

	assign step    = in_valid && !in_stall;
	assign pressed = pin_levels ~^ cfg_q.active_levels;

	for (genvar b = 0; b < NumButtons; b++) begin : g_lane
		bcgd_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.step    (step),
			.pressed (pressed[b]),
			.now     (now_ms),
			.cfg     (cfg_q),
			.ev      (ev[b])
		);
	end

	bcgd_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.ev        (ev),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.command   (command)
	);

endmodule

@@ sv/bcgd_lane.sv @@
module bcgd_lane import bcgd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                pressed,
	input  logic [TimeBits-1:0] now,
	input  cfg_t                cfg,
	output ev_t                 ev
);

	phase_t              phase_q, phase_d;
	logic [TimeBits-1:0] start_q, start_d;
	logic [TimeBits-1:0] rep_q, rep_d;
	logic [TimeBits-1:0] since_start, since_rep;
	logic                debounced, long_due, gap_over, rep_due;

	// modular elapsed times
	assign since_start = now - start_q;
	assign since_rep   = now - rep_q;
	assign debounced   = since_start >= TimeBits'(cfg.debounce_ms);
	assign long_due    = since_start >= TimeBits'(cfg.long_press_ms);
	assign gap_over    = since_start >  TimeBits'(cfg.double_gap_ms);
	assign rep_due     = since_rep   >= TimeBits'(cfg.repeat_ms);

	always_comb begin
		phase_d = phase_q;
		start_d = start_q;
		rep_d   = rep_q;
		unique case (phase_q)
			PH_PRESSED: begin
				if (!pressed) begin
					if (debounced) begin
						phase_d = PH_WAIT_DOUBLE;
						start_d = now;
					end else begin
						phase_d = PH_IDLE;
					end
				end else if (long_due) begin
					phase_d = PH_LONG;
					rep_d   = now;
				end
			end
			PH_WAIT_DOUBLE: begin
				if (pressed) begin
					phase_d = PH_SECOND;
					start_d = now;
				end else if (gap_over) begin
					phase_d = PH_IDLE;
				end
			end
			PH_SECOND: begin
				if (!pressed)
					phase_d = PH_IDLE;
			end
			PH_LONG: begin
				if (!pressed)
					phase_d = PH_IDLE;
				else if (rep_due)
					rep_d = now;
			end
			default: begin
				if (pressed) begin
					phase_d = PH_PRESSED;
					start_d = now;
				end else begin
					phase_d = PH_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		ev = EV_NONE;
		unique case (phase_q)
			PH_PRESSED:     if (pressed && long_due) ev = EV_HOLD;
			PH_WAIT_DOUBLE: if (!pressed && gap_over) ev = EV_SINGLE;
			PH_SECOND:      if (!pressed && debounced) ev = EV_DOUBLE;
			PH_LONG:        if (pressed && rep_due) ev = EV_HOLD;
			default:        ev = EV_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			phase_q <= PH_IDLE;
		else if (step)
			phase_q <= phase_d;
	end

	always_ff @(posedge clk) begin
		if (step) begin
			start_q <= start_d;
			rep_q   <= rep_d;
		end
	end

endmodule

@@ sv/bcgd_merge.sv @@
module bcgd_merge import bcgd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  ev_t        ev [NumButtons],
	input  logic       out_stall,
	output logic       in_stall,
	output logic       out_valid,
	output logic [3:0] command
);

	logic [3:0] cmd;
	logic       valid_q;
	logic [3:0] command_q;

	// walk from lowest priority up so the highest one wins
	always_comb begin
		cmd = 4'd0;
		for (int p = NumButtons - 1; p >= 0; p--) begin
			if (ev[PrioBit[p]] != EV_NONE)
				cmd = CmdBase[p] + 4'(ev[PrioBit[p]]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (step)
			valid_q <= 1'b1;
		else if (!out_stall)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step)
			command_q <= cmd;
	end

	assign in_stall  = valid_q && out_stall;
	assign out_valid = valid_q;
	assign command   = command_q;

endmodule

@@ test/tb_button_click_gesture_detector.sv @@
module tb_button_click_gesture_detector;
	import bcgd_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int LongHold   = 60;
	localparam int ReportMax  = 10;

	localparam logic [2:0] CfgSpare = 3'd7;
	localparam logic [3:0] CmdNone  = 4'd0;

	// held masks, same bit order as the pins
	localparam logic [NumButtons-1:0] BtnU   = 5'b00001;
	localparam logic [NumButtons-1:0] BtnD   = 5'b00010;
	localparam logic [NumButtons-1:0] BtnL   = 5'b00100;
	localparam logic [NumButtons-1:0] BtnR   = 5'b01000;
	localparam logic [NumButtons-1:0] BtnK   = 5'b10000;
	localparam logic [NumButtons-1:0] BtnAll = 5'b11111;

	class gesture_scoreboard;
		cfg_t                cfg;
		phase_t              phase [NumButtons];
		logic [TimeBits-1:0] phase_start [NumButtons];
		logic [TimeBits-1:0] repeat_stamp [NumButtons];
		logic [3:0]          expected_cmds [$];
		int                  mismatches;
		int                  words_seen;

		function new();
			cfg.debounce_ms   = DebounceReset;
			cfg.long_press_ms = LongPressReset;
			cfg.double_gap_ms = DoubleGapReset;
			cfg.repeat_ms     = RepeatReset;
			cfg.active_levels = ActiveReset;
			for (int b = 0; b < NumButtons; b++) begin
				phase[b]        = PH_IDLE;
				phase_start[b]  = '0;
				repeat_stamp[b] = '0;
			end
			mismatches = 0;
			words_seen = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [CfgBits-1:0] data);
			case (idx)
				CfgDebounce:    cfg.debounce_ms   = data;
				CfgLongPress:   cfg.long_press_ms = data;
				CfgDoubleGap:   cfg.double_gap_ms = data;
				CfgRepeat:      cfg.repeat_ms     = data;
				CfgActiveLevel: cfg.active_levels = data[NumButtons-1:0];
				default: ;
			endcase
		endfunction

		function ev_t advance_button(int b, bit held, logic [TimeBits-1:0] t);
			ev_t                 ev;
			logic [TimeBits-1:0] since_start;
			logic [TimeBits-1:0] since_repeat;
			ev           = EV_NONE;
			since_start  = t - phase_start[b];
			since_repeat = t - repeat_stamp[b];
			case (phase[b])
				PH_PRESSED: begin
					if (!held) begin
						if (since_start >= cfg.debounce_ms) begin
							phase[b]       = PH_WAIT_DOUBLE;
							phase_start[b] = t;
						end else begin
							phase[b] = PH_IDLE;
						end
					end else if (since_start >= cfg.long_press_ms) begin
						phase[b]        = PH_LONG;
						repeat_stamp[b] = t;
						ev              = EV_HOLD;
					end
				end
				PH_WAIT_DOUBLE: begin
					if (held) begin
						phase[b]       = PH_SECOND;
						phase_start[b] = t;
					end else if (since_start > cfg.double_gap_ms) begin
						phase[b] = PH_IDLE;
						ev       = EV_SINGLE;
					end
				end
				PH_SECOND: begin
					if (!held) begin
						if (since_start >= cfg.debounce_ms)
							ev = EV_DOUBLE;
						phase[b] = PH_IDLE;
					end
				end
				PH_LONG: begin
					if (!held) begin
						phase[b] = PH_IDLE;
					end else if (since_repeat >= cfg.repeat_ms) begin
						ev              = EV_HOLD;
						repeat_stamp[b] = t;
					end
				end
				default: begin
					if (held) begin
						phase[b]       = PH_PRESSED;
						phase_start[b] = t;
					end else begin
						phase[b] = PH_IDLE;
					end
				end
			endcase
			return ev;
		endfunction

		// every machine advances; only the first event in K,U,D,L,R order is kept
		function void note_sample(logic [NumButtons-1:0] pins, logic [TimeBits-1:0] t);
			logic [3:0] cmd;
			ev_t        ev;
			int         b;
			cmd = CmdNone;
			for (int p = 0; p < NumButtons; p++) begin
				b  = PrioBit[p];
				ev = advance_button(b, pins[b] == cfg.active_levels[b], t);
				if (cmd == CmdNone && ev != EV_NONE)
					cmd = CmdBase[p] + {2'b00, ev};
			end
			expected_cmds.push_back(cmd);
		endfunction

		function void check_command(logic [3:0] cmd);
			logic [3:0] want;
			words_seen++;
			if (expected_cmds.size() == 0) begin
				mismatches++;
				if (mismatches <= ReportMax)
					$display("word %0d: command %0d with no sample outstanding", words_seen, cmd);
				return;
			end
			want = expected_cmds.pop_front();
			if (cmd !== want) begin
				mismatches++;
				if (mismatches <= ReportMax)
					$display("word %0d: command expected %0d, got %0d", words_seen, want, cmd);
			end
		endfunction

		function int pending();
			return expected_cmds.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [NumButtons-1:0] pin_levels;
	logic [TimeBits-1:0]   now_ms;
	logic                  out_valid;
	logic                  out_stall;
	logic [3:0]            command;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [2:0]            cfg_index;
	logic [CfgBits-1:0]    cfg_data;

	gesture_scoreboard     sb;
	logic [NumButtons-1:0] act_lv;
	int                    send_idle_pct = 0;
	int                    stall_pct = 0;
	int                    hold_requests = 0;
	int                    holds_served = 0;
	int unsigned           cycle_count = 0;

	button_click_gesture_detector u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pin_levels (pin_levels),
		.now_ms     (now_ms),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.command    (command),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				sb.note_sample(pin_levels, now_ms);
			if (out_valid && !out_stall)
				sb.check_command(command);
		end
	end

	// receiver: random stalls, plus a long hold-off whenever one is requested
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_served != hold_requests) begin
				holds_served++;
				out_stall <= 1'b1;
				repeat (LongHold) @(posedge clk);
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// valid is left high after acceptance; a gap lowers it
	task automatic send_sample(input logic [NumButtons-1:0] held, input logic [TimeBits-1:0] t);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid   <= 1'b1;
		pin_levels <= act_lv ^ ~held;
		now_ms     <= t;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [CfgBits-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_settings(input logic [CfgBits-1:0] db, input logic [CfgBits-1:0] lp,
			input logic [CfgBits-1:0] gap, input logic [CfgBits-1:0] rep,
			input logic [NumButtons-1:0] act);
		drain();
		write_reg(CfgSpare, db);
		write_reg(CfgDebounce, db);
		write_reg(CfgLongPress, lp);
		write_reg(CfgDoubleGap, gap);
		write_reg(CfgRepeat, rep);
		write_reg(CfgActiveLevel, {{(CfgBits-NumButtons){1'b0}}, act});
		cfg_valid <= 1'b0;
		act_lv = act;
	endtask

	// buttons toggle at random over an advancing clock; a few words are pure noise
	task automatic run_gestures(input int count, input int step_max);
		logic [NumButtons-1:0] held;
		logic [TimeBits-1:0]   t;
		held = '0;
		t    = $urandom();
		repeat (count) begin
			if ($urandom_range(99) < 8) begin
				send_sample(NumButtons'($urandom_range(31)), $urandom());
			end else begin
				for (int b = 0; b < NumButtons; b++)
					if ($urandom_range(99) < 20)
						held[b] = ~held[b];
				t = t + $urandom_range(step_max, 0);
				send_sample(held, t);
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		pin_levels <= '0;
		now_ms     <= '0;
		cfg_valid  <= 1'b0;
		cfg_index  <= '0;
		cfg_data   <= '0;
		act_lv = ActiveReset;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: debounce 20, long 500, gap 250, repeat 100
		send_sample('0, 32'd1000);
		send_sample(BtnK, 32'd1000);
		send_sample('0, 32'd1019);           // bounce: released one short of debounce
		send_sample(BtnK, 32'd1100);
		send_sample('0, 32'd1120);           // released right at debounce
		send_sample('0, 32'd1370);           // gap equal, not yet over
		send_sample('0, 32'd1371);           // K single
		send_sample(BtnU, 32'd2000);
		send_sample('0, 32'd2020);
		send_sample(BtnU, 32'd2030);
		send_sample('0, 32'd2050);           // U double
		send_sample(BtnU, 32'd3000);
		send_sample('0, 32'd3030);
		send_sample(BtnU, 32'd3040);
		send_sample('0, 32'd3059);           // second press too short
		send_sample(BtnD, 32'd4000);
		send_sample(BtnD, 32'd4499);
		send_sample(BtnD, 32'd4500);         // D hold
		send_sample(BtnD, 32'd4599);
		send_sample(BtnD, 32'd4600);         // hold repeat
		send_sample(BtnL | BtnR, 32'd5000);
		send_sample('0, 32'd5030);
		send_sample('0, 32'd5281);           // L and R single together, L wins
		send_sample(BtnAll, 32'hFFFF_FFF0);
		send_sample(BtnAll, 32'h0000_0004);  // timestamp wraps under a held press
		send_sample('0, 32'h0000_0010);
		send_sample('0, 32'h0000_0200);      // five singles, K reported

		apply_settings(16'd5, 16'd40, 16'd15, 16'd8, 5'b10101);
		run_gestures(200, 6);

		apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 5'b11111);
		send_idle_pct = 51;
		run_gestures(150, 3);

		apply_settings(16'd3, 16'd30, 16'd12, 16'd5, 5'b01010);
		send_idle_pct = 0;
		stall_pct     = 51;
		hold_requests++;
		run_gestures(200, 5);

		apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'b00000);
		send_idle_pct = 20;
		stall_pct     = 20;
		run_gestures(100, 20000);

		apply_settings(16'd8, 16'd60, 16'd20, 16'd10, NumButtons'($urandom_range(31)));
		hold_requests++;
		run_gestures(200, 8);

		apply_settings(CfgBits'($urandom_range(30)), CfgBits'($urandom_range(80)),
				CfgBits'($urandom_range(40)), CfgBits'($urandom_range(20)),
				NumButtons'($urandom_range(31)));
		send_idle_pct = $urandom_range(60);
		stall_pct     = $urandom_range(60);
		run_gestures(150, 10);

		stall_pct = 0;
		drain();
		repeat (4) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ button_click_gesture_detector.f @@
sv/bcgd_pkg.sv
sv/bcgd_lane.sv
sv/bcgd_merge.sv
sv/button_click_gesture_detector.sv
test/tb_button_click_gesture_detector.sv
